// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, sampled on the rising clock, off while reset is low
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: check failed");

// implication checked on every clock once reset is released
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication failed");

`endif

// ===== design/gtpp_pkg.sv =====
`timescale 1ns / 1ps
package gtpp_pkg;

    localparam int FRAME_WIDTH  = 640;
    localparam int FRAME_HEIGHT = 480;

    localparam int XW = 10;
    localparam int YW = 9;
    localparam int TW = 17;
    localparam int NW = 20;

    localparam logic [TW-1:0] FRAME_LIMIT = TW'(99999);

    localparam int STAIR_ROWS  = 48;
    localparam int STAIR_STEP  = FRAME_WIDTH / 10;
    localparam int BAND_ROWS   = 24;
    localparam int SQUARE_SIZE = 40;
    localparam int TEXT_LEFT   = 16;
    localparam int TEXT_TOP    = FRAME_HEIGHT - 64;
    localparam int CELL        = 6;
    localparam int CHAR_PITCH  = 6 * CELL;

    localparam int BAND_HALF = FRAME_HEIGHT - BAND_ROWS;
    localparam int BAND_DIV  = 2 * BAND_HALF;
    localparam int SQX_DIV   = FRAME_WIDTH - SQUARE_SIZE;
    localparam int SQY_DIV   = FRAME_HEIGHT - SQUARE_SIZE;
    localparam int RAMP_DIV  = FRAME_WIDTH - 1;

    // reciprocal constants: estimate is exact or one low
    localparam int K_WIDE = 20;
    localparam int K_TICK = 17;
    localparam int K_U    = 11;
    localparam int K_W    = 9;
    localparam logic [NW-1:0] RAMP_M = NW'((1 << K_WIDE) / RAMP_DIV);
    localparam logic [NW-1:0] BAND_M = NW'((1 << K_WIDE) / BAND_DIV);
    localparam logic [NW-1:0] SQX_M  = NW'((1 << K_WIDE) / SQX_DIV);
    localparam logic [NW-1:0] SQY_M  = NW'((1 << K_WIDE) / SQY_DIV);
    localparam logic [NW-1:0] D10_M  = NW'((1 << K_TICK) / 10);
    localparam logic [NW-1:0] D100_M = NW'((1 << K_TICK) / 100);
    localparam logic [NW-1:0] D1K_M  = NW'((1 << K_TICK) / 1000);
    localparam logic [NW-1:0] D10K_M = NW'((1 << K_TICK) / 10000);
    localparam logic [NW-1:0] CHAR_M = NW'((1 << K_U) / CHAR_PITCH);
    localparam logic [NW-1:0] ROW_M  = NW'((1 << K_W) / CELL);

    localparam logic [7:0] STAIR_LEVEL [10] = '{
        8'd0, 8'd28, 8'd56, 8'd85, 8'd113, 8'd141, 8'd170, 8'd198, 8'd226, 8'd255
    };

    // bit 4 is the leftmost column; digits, then F R A M E and space
    localparam logic [4:0] GLYPH [16][7] = '{
        '{5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E},
        '{5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E},
        '{5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F},
        '{5'h1F, 5'h02, 5'h04, 5'h02, 5'h01, 5'h11, 5'h0E},
        '{5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02},
        '{5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E},
        '{5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E},
        '{5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08},
        '{5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E},
        '{5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C},
        '{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10},
        '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11},
        '{5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11},
        '{5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11},
        '{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F},
        '{5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00}
    };

    typedef struct packed {
        logic [NW-1:0] q;
        logic [NW-1:0] r;
    } t_qr;

    // printed digits, most significant first
    typedef logic [4:0][3:0] t_digits;

    function automatic t_qr div_fix(input logic [NW-1:0] n, input logic [NW-1:0] q0,
                                    input logic [NW-1:0] d);
        t_qr res;
        logic [NW-1:0] r;
        r = n - NW'(q0 * d);
        if (r >= d) begin
            res.q = q0 + NW'(1);
            res.r = r - d;
        end else begin
            res.q = q0;
            res.r = r;
        end
        return res;
    endfunction

    // ch and rr count from one (one cell/char of margin before the text)
    function automatic logic text_lit(input logic [5:0] ch, input logic [2:0] c,
                                      input logic [6:0] rr, input t_digits dig);
        logic [3:0] idx;
        logic [2:0] row;
        logic       ok;
        ok  = (ch >= 6'd1) && (ch <= 6'd11) && (c < 3'd5) && (rr >= 7'd1) && (rr <= 7'd7);
        row = 3'(rr - 7'd1);
        case (ch)
            6'd1:    idx = 4'd10;
            6'd2:    idx = 4'd11;
            6'd3:    idx = 4'd12;
            6'd4:    idx = 4'd13;
            6'd5:    idx = 4'd14;
            6'd7:    idx = dig[0];
            6'd8:    idx = dig[1];
            6'd9:    idx = dig[2];
            6'd10:   idx = dig[3];
            6'd11:   idx = dig[4];
            default: idx = 4'd15;
        endcase
        if (!ok || row == 3'd7)
            return 1'b0;
        return GLYPH[idx][row][3'd4 - c];
    endfunction

endpackage

// ===== design/gray_test_pattern_pixel.sv =====
`timescale 1ns / 1ps
// channel  | handshake        | payload
// request  | start / busy     | i_pixel_x, i_pixel_y, i_frame_number
// pixel    | o_valid strobe   | o_gray_value
//
// five register stages: clamp, reciprocal multiplies, quotient fix-up,
// layer tests, text decision; o_gray_value is driven from the last of them
// one item accepted every cycle, busy is tied low
// synchronous active-low reset clears only the valid bits
// the receiver cannot stall, so nothing is ever held back
`include "assert_macros.svh"
module gray_test_pattern_pixel import gtpp_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  logic [XW-1:0]   i_pixel_x,
    input  logic [YW-1:0]   i_pixel_y,
    input  logic [TW-1:0]   i_frame_number,
    output logic            o_valid,
    output logic [7:0]      o_gray_value
);

    logic accept;
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // valid bits
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v1 <= accept;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    // stage 1: clamp, staircase, operands
    logic [TW-1:0] n_tick;
    logic [3:0]    n_step;
    logic [12:0]   n_wext;
    always_comb begin
        n_tick = (i_frame_number > FRAME_LIMIT) ? FRAME_LIMIT : i_frame_number;
        n_step = 4'd0;
        for (int k = 1; k <= 9; k++) begin
            if ({3'b000, i_pixel_x} >= 13'(k * STAIR_STEP))
                n_step = n_step + 4'd1;
        end
        n_wext = {4'b0000, i_pixel_y} - 13'(TEXT_TOP - CELL);
    end

    logic [TW-1:0] r1_tick;
    logic [XW-1:0] r1_x;
    logic [YW-1:0] r1_y;
    logic          r1_in, r1_stair, r1_wok;
    logic [7:0]    r1_stair_val;
    logic [NW-1:0] r1_ramp_n;
    logic [NW-1:0] r1_u;
    logic [NW-1:0] r1_w;
    always_ff @(posedge i_clk) begin
        r1_tick      <= n_tick;
        r1_x         <= i_pixel_x;
        r1_y         <= i_pixel_y;
        r1_in        <= ({3'b000, i_pixel_x} < 13'(FRAME_WIDTH)) &&
                        ({4'b0000, i_pixel_y} < 13'(FRAME_HEIGHT));
        r1_stair     <= ({4'b0000, i_pixel_y} < 13'(STAIR_ROWS));
        r1_stair_val <= STAIR_LEVEL[n_step];
        r1_ramp_n    <= (NW'(i_pixel_x) << 8) - NW'(i_pixel_x);
        r1_u         <= NW'(i_pixel_x);
        r1_w         <= NW'(n_wext[YW-1:0]);
        r1_wok       <= ({4'b0000, i_pixel_y} >= 13'(TEXT_TOP - CELL));
    end

    // stage 2: reciprocal products
    logic [NW-1:0] n_band_n, n_sq_n, n_u;
    assign n_band_n = NW'(r1_tick) << 3;
    assign n_sq_n   = (NW'(r1_tick) << 2) + (NW'(r1_tick) << 1);
    // x - TEXT_LEFT + one char pitch
    // one char of margin so the outline left of the text stays positive
    assign n_u      = r1_u + NW'(CHAR_PITCH) - NW'(TEXT_LEFT);

    logic [2*NW-1:0] r2_p_ramp, r2_p_band, r2_p_sqx, r2_p_sqy;
    logic [2*NW-1:0] r2_p_d1, r2_p_d2, r2_p_d3, r2_p_d4, r2_p_u, r2_p_w;
    logic [NW-1:0]   r2_ramp_n, r2_band_n, r2_sq_n, r2_tick, r2_u, r2_w;
    logic [XW-1:0]   r2_x;
    logic [YW-1:0]   r2_y;
    logic            r2_in, r2_stair, r2_wok;
    logic [7:0]      r2_stair_val;
    always_ff @(posedge i_clk) begin
        r2_p_ramp    <= (2*NW)'(r1_ramp_n) * (2*NW)'(RAMP_M);
        r2_p_band    <= (2*NW)'(n_band_n) * (2*NW)'(BAND_M);
        r2_p_sqx     <= (2*NW)'(n_sq_n) * (2*NW)'(SQX_M);
        r2_p_sqy     <= (2*NW)'(n_sq_n) * (2*NW)'(SQY_M);
        r2_p_d1      <= (2*NW)'(r1_tick) * (2*NW)'(D10_M);
        r2_p_d2      <= (2*NW)'(r1_tick) * (2*NW)'(D100_M);
        r2_p_d3      <= (2*NW)'(r1_tick) * (2*NW)'(D1K_M);
        r2_p_d4      <= (2*NW)'(r1_tick) * (2*NW)'(D10K_M);
        r2_p_u       <= (2*NW)'(n_u) * (2*NW)'(CHAR_M);
        r2_p_w       <= (2*NW)'(r1_w) * (2*NW)'(ROW_M);
        r2_ramp_n    <= r1_ramp_n;
        r2_band_n    <= n_band_n;
        r2_sq_n      <= n_sq_n;
        r2_tick      <= NW'(r1_tick);
        r2_u         <= n_u;
        r2_w         <= r1_w;
        r2_x         <= r1_x;
        r2_y         <= r1_y;
        r2_in        <= r1_in;
        r2_stair     <= r1_stair;
        r2_wok       <= r1_wok;
        r2_stair_val <= r1_stair_val;
    end

    // stage 3: quotient fix-up
    t_qr n_ramp, n_band, n_sqx, n_sqy, n_d1, n_d2, n_d3, n_d4, n_ch, n_row;
    always_comb begin
        n_ramp = div_fix(r2_ramp_n, NW'(r2_p_ramp >> K_WIDE), NW'(RAMP_DIV));
        n_band = div_fix(r2_band_n, NW'(r2_p_band >> K_WIDE), NW'(BAND_DIV));
        n_sqx  = div_fix(r2_sq_n, NW'(r2_p_sqx >> K_WIDE), NW'(SQX_DIV));
        n_sqy  = div_fix(r2_sq_n, NW'(r2_p_sqy >> K_WIDE), NW'(SQY_DIV));
        n_d1   = div_fix(r2_tick, NW'(r2_p_d1 >> K_TICK), NW'(10));
        n_d2   = div_fix(r2_tick, NW'(r2_p_d2 >> K_TICK), NW'(100));
        n_d3   = div_fix(r2_tick, NW'(r2_p_d3 >> K_TICK), NW'(1000));
        n_d4   = div_fix(r2_tick, NW'(r2_p_d4 >> K_TICK), NW'(10000));
        n_ch   = div_fix(r2_u, NW'(r2_p_u >> K_U), NW'(CHAR_PITCH));
        n_row  = div_fix(r2_w, NW'(r2_p_w >> K_W), NW'(CELL));
    end

    logic [7:0]    r3_ramp, r3_stair_val;
    logic [12:0]   r3_band;
    logic [11:0]   r3_sqx, r3_sqy;
    logic [NW-1:0] r3_tick;
    logic [13:0]   r3_q1, r3_q2, r3_q3, r3_q4;
    logic [5:0]    r3_ch;
    logic [5:0]    r3_rem;
    logic [6:0]    r3_rr;
    logic [2:0]    r3_b;
    logic [XW-1:0] r3_x;
    logic [YW-1:0] r3_y;
    logic          r3_in, r3_stair, r3_wok;
    always_ff @(posedge i_clk) begin
        r3_ramp      <= n_ramp.q[7:0];
        r3_band      <= n_band.r[12:0];
        r3_sqx       <= n_sqx.r[11:0];
        r3_sqy       <= n_sqy.r[11:0];
        r3_tick      <= r2_tick;
        r3_q1        <= n_d1.q[13:0];
        r3_q2        <= n_d2.q[13:0];
        r3_q3        <= n_d3.q[13:0];
        r3_q4        <= n_d4.q[13:0];
        r3_ch        <= n_ch.q[5:0];
        r3_rem       <= n_ch.r[5:0];
        r3_rr        <= n_row.q[6:0];
        r3_b         <= n_row.r[2:0];
        r3_x         <= r2_x;
        r3_y         <= r2_y;
        r3_in        <= r2_in;
        r3_stair     <= r2_stair;
        r3_wok       <= r2_wok;
        r3_stair_val <= r2_stair_val;
    end

    // stage 4: band, square, digits, cell column
    logic [12:0] n_band_pos;
    logic        n_white;
    t_digits     n_dig;
    logic [2:0]  n_c;
    logic [5:0]  n_a6;
    always_comb begin
        n_band_pos = (r3_band > 13'(BAND_HALF)) ? 13'(BAND_DIV) - r3_band : r3_band;
        n_white = (({4'b0000, r3_y} >= n_band_pos) &&
                   ({4'b0000, r3_y} < n_band_pos + 13'(BAND_ROWS))) ||
                  (({3'b000, r3_x} >= {1'b0, r3_sqx}) &&
                   ({3'b000, r3_x} < {1'b0, r3_sqx} + 13'(SQUARE_SIZE)) &&
                   ({4'b0000, r3_y} >= {1'b0, r3_sqy}) &&
                   ({4'b0000, r3_y} < {1'b0, r3_sqy} + 13'(SQUARE_SIZE)));
        n_dig[0] = r3_q4[3:0];
        n_dig[1] = 4'(r3_q3 - 14'((r3_q4 << 3) + (r3_q4 << 1)));
        n_dig[2] = 4'(r3_q2 - 14'((r3_q3 << 3) + (r3_q3 << 1)));
        n_dig[3] = 4'(r3_q1 - 14'((r3_q2 << 3) + (r3_q2 << 1)));
        n_dig[4] = 4'(r3_tick[13:0] - 14'((r3_q1 << 3) + (r3_q1 << 1)));
        n_c = 3'd0;
        for (int k = 1; k <= 5; k++) begin
            if (r3_rem >= 6'(k * CELL))
                n_c = n_c + 3'd1;
        end
        n_a6 = r3_rem - (({3'b000, n_c} << 2) + ({3'b000, n_c} << 1));
    end

    logic [7:0]  r4_bg;
    logic        r4_white, r4_in, r4_wok;
    t_digits     r4_dig;
    logic [5:0]  r4_ch;
    logic [2:0]  r4_c, r4_a, r4_b;
    logic [6:0]  r4_rr;
    always_ff @(posedge i_clk) begin
        r4_bg    <= r3_stair ? r3_stair_val : r3_ramp;
        r4_white <= n_white;
        r4_in    <= r3_in;
        r4_wok   <= r3_wok;
        r4_dig   <= n_dig;
        r4_ch    <= r3_ch;
        r4_c     <= n_c;
        r4_a     <= n_a6[2:0];
        r4_b     <= r3_b;
        r4_rr    <= r3_rr;
    end

    // stage 5: fill cell versus corner-mark cell, later one in text order wins
    logic       n_o_ok, n_same, n_black, n_fill;
    logic [5:0] n_och;
    logic [2:0] n_oc;
    logic [6:0] n_orr;
    logic [7:0] n_gray;
    always_comb begin
        n_o_ok = (r4_a <= 3'd1 || r4_a == 3'd5) && (r4_b <= 3'd1 || r4_b == 3'd5);
        n_same = (r4_a <= 3'd1) && (r4_b <= 3'd1);
        n_och  = r4_ch;
        n_oc   = r4_c;
        if (r4_a == 3'd5) begin
            if (r4_c == 3'd5) begin
                n_och = r4_ch + 6'd1;
                n_oc  = 3'd0;
            end else begin
                n_oc  = r4_c + 3'd1;
            end
        end
        n_orr   = r4_rr + ((r4_b == 3'd5) ? 7'd1 : 7'd0);
        n_black = r4_wok && n_o_ok && !n_same && text_lit(n_och, n_oc, n_orr, r4_dig);
        n_fill  = r4_wok && text_lit(r4_ch, r4_c, r4_rr, r4_dig);
        if (!r4_in || n_black)
            n_gray = 8'd0;
        else if (n_fill || r4_white)
            n_gray = 8'd255;
        else
            n_gray = r4_bg;
    end

    logic [7:0] r_gray;
    always_ff @(posedge i_clk) begin
        r_gray <= n_gray;
    end

    assign o_valid      = r_v5;
    assign o_gray_value = r_gray;

    `ASSERT_IMPLY(a_latency, i_clk, i_rst_n, accept, ##5 o_valid)
    `ASSERT_IMPLY(a_no_orphan, i_clk, i_rst_n, o_valid, $past(accept, 5))
    `ASSERT_IMPLY(a_outside_black, i_clk, i_rst_n,
        o_valid && ($past(i_pixel_x, 5) >= XW'(FRAME_WIDTH)), o_gray_value == 8'd0)
    `ASSERT_CLK(a_never_busy, i_clk, i_rst_n, !busy)

endmodule

// ===== tb/gray_test_pattern_pixel_tb.sv =====
`timescale 1ns / 1ps
module gray_test_pattern_pixel_tb;
    import gtpp_pkg::*;

    typedef struct {
        logic [XW-1:0] x;
        logic [YW-1:0] y;
        logic [TW-1:0] frame;
    } t_pixel_req;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            start = 1'b0;
    logic            busy;
    logic [XW-1:0]   i_pixel_x = '0;
    logic [YW-1:0]   i_pixel_y = '0;
    logic [TW-1:0]   i_frame_number = '0;
    logic            o_valid;
    logic [7:0]      o_gray_value;

    t_pixel_req      pending_reqs[$];
    logic [7:0]      expected_grays[$];
    int              mismatches = 0;
    int              idle_pct = 21;

    gray_test_pattern_pixel dut (.*);

    always #1 i_clk = ~i_clk;

    // text glyph index for position i of "FRAME nnnnn"
    function automatic int glyph_at(int i, int tick);
        int t;
        if (i < 5)
            return 10 + i;
        if (i == 5)
            return 15;
        t = tick;
        for (int k = 10; k > i; k--)
            t = t / 10;
        return t % 10;
    endfunction

    function automatic logic [7:0] pattern_gray(t_pixel_req req);
        int x, y, tick, v, half, band, bx, by, step, cx, cy, dx, dy, g;
        x = req.x;
        y = req.y;
        tick = req.frame;
        if (tick > 99999)
            tick = 99999;
        if (x >= FRAME_WIDTH || y >= FRAME_HEIGHT)
            return 8'd0;
        if (y < 48) begin
            step = x / (FRAME_WIDTH / 10);
            if (step > 9)
                step = 9;
            v = step * 255 / 9;
        end else begin
            v = x * 255 / (FRAME_WIDTH - 1);
        end
        half = FRAME_HEIGHT - 24;
        band = (tick * 8) % (2 * half);
        if (band > half)
            band = 2 * half - band;
        if (y >= band && y < band + 24)
            v = 255;
        bx = (tick * 6) % (FRAME_WIDTH - 40);
        by = (tick * 6) % (FRAME_HEIGHT - 40);
        if (x >= bx && x < bx + 40 && y >= by && y < by + 40)
            v = 255;
        // outline painted before fill, cell by cell in text order
        for (int i = 0; i < 11; i++) begin
            g = glyph_at(i, tick);
            for (int r = 0; r < 7; r++)
                for (int c = 0; c < 5; c++) begin
                    if (GLYPH[g][r][4-c]) begin
                        cx = 16 + i * 36 + c * 6;
                        cy = FRAME_HEIGHT - 64 + r * 6;
                        dx = x - cx;
                        dy = y - cy;
                        if (dx >= -1 && dx <= 1 && dy >= -1 && dy <= 1)
                            v = 0;
                        if (dx >= 0 && dx < 6 && dy >= 0 && dy < 6)
                            v = 255;
                    end
                end
        end
        return v[7:0];
    endfunction

    function automatic t_pixel_req make_req(int x, int y, int f);
        t_pixel_req req;
        req.x = x[XW-1:0];
        req.y = y[YW-1:0];
        req.frame = f[TW-1:0];
        return req;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy)
                expected_grays.push_back(pattern_gray(
                    make_req(i_pixel_x, i_pixel_y, i_frame_number)));
            if ((!start || !busy) && pending_reqs.size() > 0
                    && $urandom_range(99, 0) >= idle_pct) begin
                t_pixel_req req;
                req = pending_reqs.pop_front();
                start <= 1'b1;
                i_pixel_x <= req.x;
                i_pixel_y <= req.y;
                i_frame_number <= req.frame;
            end else if (!start || !busy) begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (expected_grays.size() == 0) begin
                $error("gray_value: unexpected item, actual %0d", o_gray_value);
                mismatches++;
            end else begin
                logic [7:0] want;
                want = expected_grays.pop_front();
                if (want !== o_gray_value) begin
                    $error("gray_value: expected %0d, actual %0d", want, o_gray_value);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        int f, x, y;
        int text_top;
        text_top = FRAME_HEIGHT - 64;
        // corners, out-of-frame, stair edge, frame clamp, text cells
        pending_reqs.push_back(make_req(0, 0, 0));
        pending_reqs.push_back(make_req(639, 479, 0));
        pending_reqs.push_back(make_req(639, 47, 1));
        pending_reqs.push_back(make_req(640, 10, 5));
        pending_reqs.push_back(make_req(1023, 511, 131071));
        pending_reqs.push_back(make_req(5, 480, 7));
        pending_reqs.push_back(make_req(100, 100, 99999));
        pending_reqs.push_back(make_req(100, 100, 100000));
        pending_reqs.push_back(make_req(576, 48, 0));
        pending_reqs.push_back(make_req(0, 48, 57));
        pending_reqs.push_back(make_req(300, 470, 57));
        pending_reqs.push_back(make_req(16, text_top, 12345));
        pending_reqs.push_back(make_req(15, text_top - 1, 12345));
        pending_reqs.push_back(make_req(17, text_top + 1, 12345));
        pending_reqs.push_back(make_req(230, text_top + 20, 67890));
        pending_reqs.push_back(make_req(400, text_top + 40, 88888));
        pending_reqs.push_back(make_req(320, 240, 38));
        pending_reqs.push_back(make_req(639, 470, 114));
        pending_reqs.push_back(make_req(0, 479, 57));
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int n = 0; n < 2000; n++) begin
            if (n == 700)
                idle_pct = 78;
            else if (n == 1400)
                idle_pct = 0;
            f = $urandom_range(3) == 0 ? $urandom_range(131071) : $urandom_range(99999);
            case ($urandom_range(3))
                0: begin
                    // one draw in four lands on the text strip
                    x = $urandom_range(420, 10);
                    y = $urandom_range(text_top + 45, text_top - 3);
                end
                1: begin
                    x = $urandom_range(1023);
                    y = $urandom_range(511);
                end
                default: begin
                    x = $urandom_range(639);
                    y = $urandom_range(479);
                end
            endcase
            pending_reqs.push_back(make_req(x, y, f));
            while (pending_reqs.size() > 16)
                @(posedge i_clk);
        end
        while (pending_reqs.size() > 0 || start)
            @(posedge i_clk);
        while (expected_grays.size() > 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && expected_grays.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #200000;
        $display("Mismatches found");
        $finish;
    end
endmodule
